// ----- hw/rtl/uart_baud_divisor_calc_defines.svh -----
// assertion macros for the baud divisor calculator
`ifndef UART_BAUD_DIVISOR_CALC_DEFINES_SVH
`define UART_BAUD_DIVISOR_CALC_DEFINES_SVH

// antecedent implies consequent, checked on clk_i outside reset
`define UDC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// condition never holds outside reset
`define UDC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// ----- hw/rtl/udc_pkg.sv -----
// types and constants shared by the baud divisor calculator
`timescale 1ns / 1ps
package udc_pkg;

  localparam int unsigned ClkW     = 28;
  localparam int unsigned BaudW    = 24;
  localparam int unsigned NumW     = 33;
  localparam int unsigned DenW     = 26;
  localparam int unsigned RemW     = DenW;
  localparam int unsigned NumCells = NumW;
  localparam int unsigned MantW    = 12;
  localparam int unsigned FracW    = 4;
  localparam int unsigned WordW    = MantW + FracW;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned PostStages = 3;
  localparam int unsigned Latency  = 1 + NumCells + PostStages;

  localparam logic [ClkW-1:0] ClockReset = ClkW'(16000000);
  localparam int unsigned ClockMul  = 25;
  localparam int unsigned Hundred   = 100;
  localparam int unsigned RoundHalf = 50;
  localparam int unsigned HundLimit = 4096 * Hundred;
  localparam int unsigned HundLoW   = 19;
  localparam int unsigned RecipW    = 20;
  localparam int unsigned RecipShift = 26;
  localparam int unsigned RecipHund = (2 ** RecipShift + Hundred - 1) / Hundred;
  localparam int unsigned RemHW     = 7;
  localparam int unsigned RndW      = 11;
  localparam int unsigned FracRecipW = 14;
  localparam int unsigned FracShift = 20;
  localparam int unsigned FracRecip = (2 ** FracShift + Hundred - 1) / Hundred;
  localparam int unsigned FracQW    = 5;
  localparam logic [FracQW-1:0] StepsX16 = FracQW'(16);
  localparam logic [FracQW-1:0] StepsX8  = FracQW'(8);
  localparam logic [MantW-1:0] MantMax = {MantW{1'b1}};

  localparam logic [CfgIdxW-1:0] CfgClock      = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgOversample = 1'b1;

  typedef enum logic [StatusW-1:0] {
    StatusOk       = 2'd0,
    StatusBaudZero = 2'd1,
    StatusSat      = 2'd2
  } status_e;

  typedef struct packed {
    logic            valid;
    logic            zero;
    logic [DenW-1:0] den;
    logic [RemW-1:0] rem;
    logic [NumW-1:0] acc;
  } cell_t;

  typedef struct packed {
    logic             valid;
    logic [WordW-1:0] word;
    logic [MantW-1:0] mant;
    logic [FracW-1:0] frac;
    status_e          status;
  } res_t;

endpackage

// ----- hw/rtl/udc_div_cell.sv -----
// one restoring division cell: a quotient bit per cycle
`timescale 1ns / 1ps
module udc_div_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  udc_pkg::cell_t cell_i,
  output udc_pkg::cell_t cell_o
);
  import udc_pkg::*;

  logic [RemW:0]   trial;
  logic [RemW:0]   diff;
  logic            ge;
  logic [RemW-1:0] rem_d;
  logic [NumW-1:0] acc_d;
  logic            valid_q;
  logic            zero_q;
  logic [DenW-1:0] den_q;
  logic [RemW-1:0] rem_q;
  logic [NumW-1:0] acc_q;

  always_comb begin
    trial = {cell_i.rem, cell_i.acc[NumW-1]};
    ge    = trial >= {1'b0, cell_i.den};
    diff  = trial - {1'b0, cell_i.den};
    rem_d = ge ? diff[RemW-1:0] : trial[RemW-1:0];
    acc_d = {cell_i.acc[NumW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cell_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    zero_q <= cell_i.zero;
    den_q  <= cell_i.den;
    rem_q  <= rem_d;
    acc_q  <= acc_d;
  end

  assign cell_o = '{valid: valid_q, zero: zero_q, den: den_q, rem: rem_q, acc: acc_q};

endmodule

// ----- hw/rtl/udc_post.sv -----
// splits the hundredths into mantissa and fraction, rounds and saturates
`timescale 1ns / 1ps
module udc_post (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           by8_i,
  input  udc_pkg::cell_t cell_i,
  output udc_pkg::res_t  res_o
);
  import udc_pkg::*;

  typedef struct packed {
    logic               valid;
    logic               zero;
    logic               over;
    logic [MantW-1:0]   mant;
    logic [HundLoW-1:0] hund;
  } p1_t;

  typedef struct packed {
    logic             valid;
    logic             zero;
    logic             over;
    logic [MantW-1:0] mant;
    logic [RemHW-1:0] rem;
  } p2_t;

  logic [HundLoW+RecipW-1:0]  mant_prod;
  logic [HundLoW-1:0]         hund_part;
  logic [HundLoW-1:0]         rem_full;
  logic [RndW-1:0]            rnd;
  logic [RndW+FracRecipW-1:0] frac_prod;
  logic [FracQW-1:0]          frac_q5;
  logic [FracQW-1:0]          steps;
  logic                       carry;
  logic [MantW:0]             mant_c;
  logic [FracW-1:0]           frac_c;
  p1_t                        p1_d, p1_q;
  p2_t                        p2_d, p2_q;
  res_t                       res_d, res_q;

  always_comb begin
    mant_prod  = (HundLoW+RecipW)'(cell_i.acc[HundLoW-1:0]) * (HundLoW+RecipW)'(RecipHund);
    p1_d.valid = cell_i.valid;
    p1_d.zero  = cell_i.zero;
    p1_d.over  = cell_i.acc >= NumW'(HundLimit);
    p1_d.mant  = mant_prod[RecipShift +: MantW];
    p1_d.hund  = cell_i.acc[HundLoW-1:0];
  end

  always_comb begin
    hund_part  = HundLoW'(p1_q.mant) * HundLoW'(Hundred);
    rem_full   = p1_q.hund - hund_part;
    p2_d.valid = p1_q.valid;
    p2_d.zero  = p1_q.zero;
    p2_d.over  = p1_q.over;
    p2_d.mant  = p1_q.mant;
    p2_d.rem   = rem_full[RemHW-1:0];
  end

  always_comb begin
    steps     = by8_i ? StepsX8 : StepsX16;
    rnd       = by8_i ? RndW'({p2_q.rem, 3'b000}) : RndW'({p2_q.rem, 4'b0000});
    rnd       = rnd + RndW'(RoundHalf);
    frac_prod = (RndW+FracRecipW)'(rnd) * (RndW+FracRecipW)'(FracRecip);
    frac_q5   = frac_prod[FracShift +: FracQW];
    carry     = frac_q5 >= steps;
    mant_c    = {1'b0, p2_q.mant} + (MantW+1)'(carry);
    frac_c    = carry ? '0 : frac_q5[FracW-1:0];
    res_d.valid = p2_q.valid;
    if (p2_q.zero) begin
      res_d.mant   = '0;
      res_d.frac   = '0;
      res_d.status = StatusBaudZero;
    end else if (p2_q.over || mant_c[MantW]) begin
      res_d.mant   = MantMax;
      res_d.frac   = FracW'(steps - FracQW'(1));
      res_d.status = StatusSat;
    end else if (mant_c == '0) begin
      res_d.mant   = MantW'(1);
      res_d.frac   = '0;
      res_d.status = StatusSat;
    end else begin
      res_d.mant   = mant_c[MantW-1:0];
      res_d.frac   = frac_c;
      res_d.status = StatusOk;
    end
    res_d.word = {res_d.mant, res_d.frac};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_q  <= '0;
      p2_q  <= '0;
      res_q <= '0;
    end else begin
      p1_q  <= p1_d;
      p2_q  <= p2_d;
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ----- hw/rtl/uart_baud_divisor_calc.sv -----
// top level of the uart baud divisor calculator
`timescale 1ns / 1ps
`include "uart_baud_divisor_calc_defines.svh"
// Takes one baud rate request per clock: busy_o never rises, so start_i may be
// held high every cycle. Each result appears on the result ports marked by
// done_o for exactly one cycle, in request order; it must be captured then, as
// the block cannot be stalled. Requests pass one entry stage, the row of 33
// restoring division cells (one quotient bit each) and three stages that split,
// round and saturate the divider.
// Configuration writes are always ready; an oversampling write takes effect on
// in-flight requests, so write them only while no request is outstanding.
module uart_baud_divisor_calc (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [udc_pkg::BaudW-1:0]     baud_rate_i,
  output logic                          done_o,
  output logic [udc_pkg::WordW-1:0]     divisor_word_o,
  output logic [udc_pkg::MantW-1:0]     divider_mantissa_o,
  output logic [udc_pkg::FracW-1:0]     divider_fraction_o,
  output logic [udc_pkg::StatusW-1:0]   status_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [udc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [udc_pkg::ClkW-1:0]      cfg_data_i
);
  import udc_pkg::*;

  logic [ClkW-1:0] clock_hz_q;
  logic            by8_q;
  logic            accept;
  cell_t           front_d;
  cell_t           front_q;
  cell_t           chain [NumCells+1];
  res_t            res;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_hz_q <= ClockReset;
      by8_q      <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgClock:      clock_hz_q <= cfg_data_i;
        CfgOversample: by8_q      <= cfg_data_i[0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    front_d.valid = accept;
    front_d.zero  = baud_rate_i == '0;
    front_d.den   = by8_q ? DenW'({baud_rate_i, 1'b0}) : DenW'({baud_rate_i, 2'b00});
    front_d.rem   = '0;
    front_d.acc   = NumW'(clock_hz_q) * NumW'(ClockMul);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
    end else begin
      front_q <= front_d;
    end
  end

  assign chain[0] = front_q;

  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    udc_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cell_i (chain[g]),
      .cell_o (chain[g+1])
    );
  end

  udc_post u_post (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .by8_i  (by8_q),
    .cell_i (chain[NumCells]),
    .res_o  (res)
  );

  assign done_o             = res.valid;
  assign divisor_word_o     = res.word;
  assign divider_mantissa_o = res.mant;
  assign divider_fraction_o = res.frac;
  assign status_o           = res.status;

  `UDC_ASSERT_IMP(a_zero_baud_flagged, accept && baud_rate_i == '0, ##Latency (done_o && status_o == StatusBaudZero), "zero baud request not flagged at expected latency")
  `UDC_ASSERT_IMP(a_nonzero_baud_done, accept && baud_rate_i != '0, ##Latency (done_o && status_o != StatusBaudZero), "nonzero baud request lost or misflagged")
  `UDC_ASSERT_NEVER(a_x8_fraction, done_o && by8_q && divider_fraction_o[FracW-1], "eighths fraction uses top bit")
  `UDC_ASSERT_NEVER(a_sat_value, done_o && status_o == StatusSat && divider_mantissa_o != MantMax && divider_mantissa_o != MantW'(1), "saturated mantissa not at a limit")

endmodule

// ----- tb/sv/tb_top.sv -----
// testbench for the uart baud divisor calculator: directed and random baud requests checked by a scoreboard
`timescale 1ns / 1ps
module tb_top;
  import udc_pkg::*;

  localparam int unsigned StallLimit = 1000;
  localparam int unsigned NumPhases  = 8;
  localparam int unsigned PhaseItems = 235;

  typedef struct packed {
    logic [WordW-1:0] word;
    logic [MantW-1:0] mant;
    logic [FracW-1:0] frac;
    status_e          status;
  } divisor_t;

  class divisor_scoreboard;
    logic [ClkW-1:0] clock_hz;
    logic            by_eight;
    divisor_t        expected_divisors[$];
    int unsigned     errors;

    function new();
      clock_hz = ClockReset;
      by_eight = 1'b0;
      errors   = 0;
    endfunction

    function void write_register(logic [CfgIdxW-1:0] idx, logic [ClkW-1:0] data);
      if (idx == CfgClock) begin
        clock_hz = data;
      end else if (idx == CfgOversample) begin
        by_eight = data[0];
      end
    endfunction

    function divisor_t compute_divisor(logic [BaudW-1:0] baud);
      divisor_t    d;
      logic [63:0] steps;
      logic [63:0] hund;
      logic [63:0] mant;
      logic [63:0] rem;
      logic [63:0] frac;
      if (baud == '0) begin
        d.word   = '0;
        d.mant   = '0;
        d.frac   = '0;
        d.status = StatusBaudZero;
        return d;
      end
      steps = by_eight ? 64'd8 : 64'd16;
      hund  = (64'd25 * clock_hz) / ((by_eight ? 64'd2 : 64'd4) * baud);
      mant  = hund / 64'd100;
      rem   = hund - mant * 64'd100;
      frac  = (rem * steps + 64'd50) / 64'd100;
      d.status = StatusOk;
      // rounding up to a whole unit moves into the mantissa
      if (frac >= steps) begin
        mant = mant + 64'd1;
        frac = '0;
      end
      if (mant < 64'd1) begin
        mant     = 64'd1;
        frac     = '0;
        d.status = StatusSat;
      end else if (mant > 64'(MantMax)) begin
        mant     = 64'(MantMax);
        frac     = steps - 64'd1;
        d.status = StatusSat;
      end
      d.mant = mant[MantW-1:0];
      d.frac = frac[FracW-1:0];
      d.word = {d.mant, d.frac};
      return d;
    endfunction

    function void note_request(logic [BaudW-1:0] baud);
      expected_divisors.push_back(compute_divisor(baud));
    endfunction

    function void compare_field(string name, logic [31:0] expv, logic [31:0] actv);
      if (actv !== expv) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
        errors++;
      end
    endfunction

    function void check_result(logic [WordW-1:0] word, logic [MantW-1:0] mant,
                               logic [FracW-1:0] frac, logic [StatusW-1:0] status);
      divisor_t d;
      if (expected_divisors.size() == 0) begin
        $display("%0t: result with no request outstanding, expected none, actual word %0d",
                 $time, word);
        errors++;
        return;
      end
      d = expected_divisors.pop_front();
      compare_field("divisor_word", 32'(d.word), 32'(word));
      compare_field("divider_mantissa", 32'(d.mant), 32'(mant));
      compare_field("divider_fraction", 32'(d.frac), 32'(frac));
      compare_field("status", 32'(d.status), 32'(status));
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [BaudW-1:0]    baud_rate_i;
  logic                done_o;
  logic [WordW-1:0]    divisor_word_o;
  logic [MantW-1:0]    divider_mantissa_o;
  logic [FracW-1:0]    divider_fraction_o;
  logic [StatusW-1:0]  status_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [ClkW-1:0]     cfg_data_i;

  divisor_scoreboard sb = new();
  int unsigned       stall_cycles;

  uart_baud_divisor_calc i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .baud_rate_i        (baud_rate_i),
    .done_o             (done_o),
    .divisor_word_o     (divisor_word_o),
    .divider_mantissa_o (divider_mantissa_o),
    .divider_fraction_o (divider_fraction_o),
    .status_o           (status_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // transaction monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stall_cycles <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        sb.write_register(cfg_index_i, cfg_data_i);
      end
      if (start_i && !busy_o) begin
        sb.note_request(baud_rate_i);
      end
      if (done_o) begin
        sb.check_result(divisor_word_o, divider_mantissa_o, divider_fraction_o, status_o);
      end
      if ((cfg_valid_i && cfg_ready_o) || (start_i && !busy_o) || done_o) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    stall_cycles = 0;
    while (stall_cycles < StallLimit) @(posedge clk_i);
    $display("tb_top: FAIL");
    $finish;
  end

  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [ClkW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_divider_config(input logic [ClkW-1:0] clock_hz, input logic by_eight);
    logic [ClkW-1:0] mode_word;
    mode_word = ClkW'({$urandom, by_eight});
    if ($urandom_range(1)) begin
      write_register(CfgClock, clock_hz);
      write_register(CfgOversample, mode_word);
    end else begin
      write_register(CfgOversample, mode_word);
      write_register(CfgClock, clock_hz);
    end
  endtask

  task automatic send_request(input logic [BaudW-1:0] baud);
    @(negedge clk_i);
    start_i     <= 1'b1;
    baud_rate_i <= baud;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic hold_off(input int unsigned cycles);
    @(negedge clk_i);
    start_i <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (sb.expected_divisors.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [BaudW-1:0] pick_baud();
    int unsigned kind;
    int unsigned bits;
    logic [BaudW-1:0] common_rates[8];
    common_rates = '{24'd1200, 24'd9600, 24'd19200, 24'd38400, 24'd57600,
                     24'd115200, 24'd460800, 24'd921600};
    kind = $urandom_range(19);
    if (kind == 0) begin
      return '0;
    end else if (kind <= 3) begin
      return BaudW'($urandom_range(12000000));
    end else if (kind == 4) begin
      return BaudW'($urandom);
    end else if (kind <= 7) begin
      return common_rates[$urandom_range(7)];
    end
    // spread over magnitudes so both saturation sides and the normal range are hit
    bits = $urandom_range(1, BaudW);
    return BaudW'($urandom & ((32'd1 << bits) - 32'd1));
  endfunction

  initial begin
    logic [BaudW-1:0] directed_bauds[14];
    logic [ClkW-1:0]  clock_hz;
    logic             by_eight;
    int unsigned      idle_pct;

    rst_ni      = 1'b0;
    start_i     = 1'b0;
    baud_rate_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgClock;
    cfg_data_i  = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset clock and x16: zero baud, carry into mantissa, both saturations, all-ones
    directed_bauds = '{24'd0, 24'd1, 24'd9600, 24'd115200, 24'd91157, 24'd244, 24'd245,
                       24'd1000000, 24'd1000001, 24'd12000000, 24'hFFFFFF, 24'h800000,
                       24'h555555, 24'hAAAAAA};
    foreach (directed_bauds[i]) send_request(directed_bauds[i]);
    drain_results();

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: begin clock_hz = 28'd180000000; by_eight = 1'b1; end
        1: begin clock_hz = 28'hFFFFFFF;   by_eight = 1'b0; end
        2: begin clock_hz = 28'd1;         by_eight = 1'b1; end
        3: begin clock_hz = 28'd0;         by_eight = 1'b0; end
        4: begin clock_hz = 28'd8000000;   by_eight = 1'b1; end
        5: begin clock_hz = ClkW'($urandom); by_eight = 1'($urandom_range(1)); end
        default: begin
          clock_hz = ClkW'($urandom_range(180000000, 1000000));
          by_eight = 1'($urandom_range(1));
        end
      endcase
      set_divider_config(clock_hz, by_eight);
      idle_pct = (p == NumPhases - 1) ? 0 : ((p % 3 == 2) ? 0 : 30);
      for (int n = 0; n < PhaseItems; n++) begin
        send_request(pick_baud());
        if ($urandom_range(99) < idle_pct) hold_off($urandom_range(6, 1));
      end
      drain_results();
    end

    repeat (Latency + 8) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
